// ----- rtl/cpq_pkg.sv -----
// Shared types and constants for the four-class priority queue.
`timescale 1ns / 1ps
`default_nettype none
package cpq_pkg;

  localparam int unsigned IdW        = 16;
  localparam int unsigned NumClasses = 4;
  localparam int unsigned ClsW       = 2;

  // Class number is {is_cargo, is_large}.
  localparam logic [ClsW-1:0] CLS_SMALL_PAX   = 2'd0;
  localparam logic [ClsW-1:0] CLS_LARGE_PAX   = 2'd1;
  localparam logic [ClsW-1:0] CLS_SMALL_CARGO = 2'd2;
  localparam logic [ClsW-1:0] CLS_LARGE_CARGO = 2'd3;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ENQ   = 2'd1,
    ACT_DEQ   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Commands from the top level to one class queue.
  typedef struct packed {
    logic clr;
    logic enq;
    logic deq;
  } cls_ctrl_t;

  // Occupancy flags from one class queue.
  typedef struct packed {
    logic empty;
    logic full;
  } cls_stat_t;

endpackage
`default_nettype wire

// ----- rtl/cpq_cell.sv -----
// One storage cell of a class queue chain: loads a new item or takes its neighbor's entry.
`timescale 1ns / 1ps
`default_nettype none
module cpq_cell (
  input  wire logic                    clk_i,
  input  wire logic                    load_i,
  input  wire logic                    shift_i,
  input  wire logic [cpq_pkg::IdW-1:0] load_data_i,
  input  wire logic [cpq_pkg::IdW-1:0] next_data_i,
  output logic      [cpq_pkg::IdW-1:0] data_o
);
  import cpq_pkg::*;

  logic [IdW-1:0] data_q;
  logic [IdW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- rtl/cpq_class.sv -----
// One class FIFO built as a chain of cells, head in cell zero, with its fill count.
`timescale 1ns / 1ps
`default_nettype none
module cpq_class #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cpq_pkg::cls_ctrl_t      ctrl_i,
  input  wire logic [cpq_pkg::IdW-1:0] id_i,
  output cpq_pkg::cls_stat_t           stat_o,
  output logic      [cpq_pkg::IdW-1:0] head_o
);
  import cpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            empty;
  logic            full;
  logic            do_enq;
  logic            do_deq;
  logic [IdW-1:0]  cell_data [DEPTH];

  assign empty  = (count_q == '0);
  assign full   = (count_q == CntW'(DEPTH));
  assign do_enq = ctrl_i.enq && !full;
  assign do_deq = ctrl_i.deq && !empty;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clr) begin
      count_d = '0;
    end else if (do_enq) begin
      count_d = count_q + CntW'(1);
    end else if (do_deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // A dequeue moves every entry one cell toward the head; an enqueue lands
  // in the first free cell, whose index equals the fill count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [IdW-1:0] next_data;
    if (i == DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end
    cpq_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (do_enq && (count_q == CntW'(i))),
      .shift_i     (do_deq),
      .load_data_i (id_i),
      .next_data_i (next_data),
      .data_o      (cell_data[i])
    );
  end

  assign stat_o.empty = empty;
  assign stat_o.full  = full;
  assign head_o       = cell_data[0];

endmodule
`default_nettype wire

// ----- rtl/four_class_priority_queue_unit.sv -----
// Top level of the four-class strict-priority aircraft queue.
`timescale 1ns / 1ps
`default_nettype none
// This block keeps four FIFO queues of 16-bit aircraft identifiers, one per
// class, where the class of an item is {is_cargo, is_large}. Every accepted
// request item produces exactly one result item. Action 0 empties all four
// queues (status 0), action 1 appends the identifier to its class (status 0,
// or status 3 with the item dropped when that class already holds
// CLASS_DEPTH entries), action 2 pops the head of the first non-empty class
// in the order large passenger, small passenger, large cargo, small cargo
// (status 1 with identifier and class flags, or status 2 when all queues are
// empty). Action 3 changes nothing and returns status 0. Identifier and flags
// read zero unless status is 1. Each class is a chain of CLASS_DEPTH cells
// with its head in the first cell, so a dequeue shifts the chain by one and
// the head is always read from a fixed place. A request is decided in the
// cycle it is accepted and its result is held in an output register, so the
// block takes one item per clock cycle; it only stalls its input while a
// finished result is waiting and the output side is stalled. The result of
// an item appears in the cycle after it is accepted. There is no clearing pass
// after reset: the fill counts reset to zero, and cell contents are only ever
// read once written.
module four_class_priority_queue_unit #(
  parameter int unsigned CLASS_DEPTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              action_i,
  input  wire logic [cpq_pkg::IdW-1:0] aircraft_id_i,
  input  wire logic                    is_cargo_i,
  input  wire logic                    is_large_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [1:0]                   status_o,
  output logic      [cpq_pkg::IdW-1:0] out_id_o,
  output logic                         out_cargo_o,
  output logic                         out_large_o
);
  import cpq_pkg::*;

  cls_ctrl_t      ctrl  [NumClasses];
  cls_stat_t      stat  [NumClasses];
  logic [IdW-1:0] head  [NumClasses];

  logic            accept;
  logic [ClsW-1:0] sel;
  logic [ClsW-1:0] grant;
  logic            found;

  status_e         status_d;
  logic [IdW-1:0]  id_d;
  logic            cargo_d;
  logic            large_d;

  logic            out_valid_q;
  status_e         status_q;
  logic [IdW-1:0]  id_q;
  logic            cargo_q;
  logic            large_q;

  // The input waits only while a result is held and the output is stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign sel        = {is_cargo_i, is_large_i};

  // Strict priority pick among the non-empty classes.
  always_comb begin
    grant = CLS_SMALL_CARGO;
    found = 1'b1;
    priority if (!stat[CLS_LARGE_PAX].empty) begin
      grant = CLS_LARGE_PAX;
    end else if (!stat[CLS_SMALL_PAX].empty) begin
      grant = CLS_SMALL_PAX;
    end else if (!stat[CLS_LARGE_CARGO].empty) begin
      grant = CLS_LARGE_CARGO;
    end else if (!stat[CLS_SMALL_CARGO].empty) begin
      grant = CLS_SMALL_CARGO;
    end else begin
      found = 1'b0;
    end
  end

  // Request decode: commands to the class queues and the result fields.
  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      ctrl[c] = '0;
    end
    status_d = ST_DONE;
    id_d     = '0;
    cargo_d  = 1'b0;
    large_d  = 1'b0;
    unique case (action_e'(action_i))
      ACT_CLEAR: begin
        for (int c = 0; c < NumClasses; c++) begin
          ctrl[c].clr = accept;
        end
      end
      ACT_ENQ: begin
        if (stat[sel].full) begin
          status_d = ST_FULL;
        end else begin
          ctrl[sel].enq = accept;
        end
      end
      ACT_DEQ: begin
        if (found) begin
          ctrl[grant].deq = accept;
          status_d        = ST_DEQ;
          id_d            = head[grant];
          cargo_d         = grant[1];
          large_d         = grant[0];
        end else begin
          status_d = ST_EMPTY;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  for (genvar c = 0; c < NumClasses; c++) begin : g_class
    cpq_class #(
      .DEPTH (CLASS_DEPTH)
    ) u_class (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[c]),
      .id_i   (aircraft_id_i),
      .stat_o (stat[c]),
      .head_o (head[c])
    );
  end

  // Output register: loads on every accepted item, drains when not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      id_q     <= id_d;
      cargo_q  <= cargo_d;
      large_q  <= large_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_id_o    = id_q;
  assign out_cargo_o = cargo_q;
  assign out_large_o = large_q;

endmodule
`default_nettype wire

// ----- rtl/cpq_checker.sv -----
// Port-level checks of the priority queue and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cpq_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic [1:0]              action_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [1:0]              status_o,
  input wire logic [cpq_pkg::IdW-1:0] out_id_o,
  input wire logic                    out_cargo_o,
  input wire logic                    out_large_o
);
  import cpq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_id_o) && $stable(status_o))
    else $error("stalled result changed");

  // Identifier and flags are zero unless an item was dequeued.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DEQ) |->
      (out_id_o == '0) && !out_cargo_o && !out_large_o)
    else $error("non-zero fields without a dequeue");

  // A clear reports done in the next cycle.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_CLEAR) |=> out_valid_o && (status_o == ST_DONE))
    else $error("clear did not report done");

  // An enqueue reports done or full.
  a_enq_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_ENQ) |=>
      out_valid_o && ((status_o == ST_DONE) || (status_o == ST_FULL)))
    else $error("bad enqueue status");

  // A dequeue reports a popped item or all queues empty.
  a_deq_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_DEQ) |=>
      out_valid_o && ((status_o == ST_DEQ) || (status_o == ST_EMPTY)))
    else $error("bad dequeue status");

endmodule

bind four_class_priority_queue_unit cpq_checker u_cpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .out_id_o    (out_id_o),
  .out_cargo_o (out_cargo_o),
  .out_large_o (out_large_o)
);
`default_nettype wire

// ----- tb/tb_four_class_priority_queue_unit.sv -----
// Self-checking testbench for the four-class strict-priority aircraft queue.
`timescale 1ns / 1ps
// The testbench runs a short directed sequence and then a long random stream
// of request items against four_class_priority_queue_unit. A behavioral copy
// of the four class queues lives in this module. Every accepted request item
// is run through that copy, and the result it yields is queued as the
// expected result. A checker process pops the oldest expected result for every
// result item that the block hands over and compares it field by field.
//
// Both handshake sides idle at random so that gaps land on every phase of the
// block's work. One long stretch runs with no idling at all. The backpressure
// test holds the output side off for a long counted hold while the sender keeps
// offering items, and then lets the sender pause until every result is back.
module tb_four_class_priority_queue_unit;
  import cpq_pkg::*;

  localparam int unsigned CLASS_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned IDLE_PCT    = 12;

  // Action code 3 has no meaning; the block must treat it as a no-op.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Service order, lowest slice first: large passenger, small passenger,
  // large cargo, small cargo.
  localparam logic [4*ClsW-1:0] SERVE_ORDER =
    {CLS_SMALL_CARGO, CLS_LARGE_CARGO, CLS_SMALL_PAX, CLS_LARGE_PAX};

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   id;
    logic             cargo;
    logic             large_flag;
  } tower_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [1:0]       action_i      = ACT_CLEAR;
  logic [IdW-1:0]   aircraft_id_i = '0;
  logic             is_cargo_i    = 1'b0;
  logic             is_large_i    = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [1:0]       status_o;
  logic [IdW-1:0]   out_id_o;
  logic             out_cargo_o;
  logic             out_large_o;

  // Behavioral copy of the four class queues.
  logic [IdW-1:0]   class_slots [NumClasses][CLASS_DEPTH];
  int unsigned      head_idx    [NumClasses];
  int unsigned      tail_idx    [NumClasses];
  int unsigned      fill_cnt    [NumClasses];

  tower_result_t    pending_results[$];
  int unsigned      fail_cnt    = 0;
  int unsigned      cycle_cnt   = 0;
  bit               idle_en     = 1'b1;

  // The test raises hold_orders; the receiver process starts one long hold
  // each time it sees the count move and counts the hold down by itself.
  int unsigned      hold_orders = 0;
  int unsigned      hold_seen   = 0;
  int unsigned      hold_left   = 0;

  four_class_priority_queue_unit #(
    .CLASS_DEPTH(CLASS_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .aircraft_id_i(aircraft_id_i),
    .is_cargo_i   (is_cargo_i),
    .is_large_i   (is_large_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_id_o     (out_id_o),
    .out_cargo_o  (out_cargo_o),
    .out_large_o  (out_large_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one request to the behavioral queues and returns the result that
  // the block must produce for it.
  function automatic tower_result_t next_queue_result(logic [1:0] act,
                                                      logic [IdW-1:0] id,
                                                      logic cargo,
                                                      logic large_flag);
    tower_result_t res;
    logic [ClsW-1:0] cls;
    bit served;
    res.status     = ST_DONE;
    res.id         = '0;
    res.cargo      = 1'b0;
    res.large_flag = 1'b0;
    served         = 1'b0;
    case (act)
      ACT_CLEAR: begin
        for (int c = 0; c < NumClasses; c++) begin
          head_idx[c] = 0;
          tail_idx[c] = 0;
          fill_cnt[c] = 0;
        end
      end
      ACT_ENQ: begin
        cls = {cargo, large_flag};
        if (fill_cnt[cls] >= CLASS_DEPTH) begin
          // A full class drops the item and leaves every queue as it was.
          res.status = ST_FULL;
        end else begin
          class_slots[cls][tail_idx[cls]] = id;
          tail_idx[cls] = (tail_idx[cls] + 1) % CLASS_DEPTH;
          fill_cnt[cls]++;
        end
      end
      ACT_DEQ: begin
        res.status = ST_EMPTY;
        for (int k = 0; k < NumClasses; k++) begin
          cls = SERVE_ORDER[k*ClsW +: ClsW];
          if (!served && fill_cnt[cls] > 0) begin
            res.status     = ST_DEQ;
            res.id         = class_slots[cls][head_idx[cls]];
            res.cargo      = cls[1];
            res.large_flag = cls[0];
            head_idx[cls] = (head_idx[cls] + 1) % CLASS_DEPTH;
            fill_cnt[cls]--;
            served = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Offers one request item, holds it until the block takes it, and then
  // records the expected result. Called right after a rising edge.
  task automatic send_item(logic [1:0] act, logic [IdW-1:0] id, logic cargo,
                           logic large_flag);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    aircraft_id_i <= id;
    is_cargo_i    <= cargo;
    is_large_i    <= large_flag;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_results.push_back(next_queue_result(act, id, cargo, large_flag));
  endtask

  // The sender goes quiet until every outstanding result has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Dequeue and the unused code on empty queues, and the unused code between
  // an enqueue and its dequeue.
  task automatic test_empty_and_unused();
    send_item(ACT_CLEAR, 16'hFFFF, 1'b1, 1'b1);
    send_item(ACT_DEQ, 16'hFFFF, 1'b1, 1'b1);
    send_item(ACT_UNUSED, 16'hFFFF, 1'b1, 1'b1);
    send_item(ACT_DEQ, 16'h0000, 1'b0, 1'b0);
    send_item(ACT_ENQ, 16'h1234, 1'b1, 1'b0);
    send_item(ACT_UNUSED, 16'h0000, 1'b0, 1'b1);
    send_item(ACT_DEQ, 16'h0000, 1'b0, 1'b0);
    send_item(ACT_DEQ, 16'h0000, 1'b0, 1'b0);
  endtask

  // Items go in against the priority order and must come out in it, with
  // the extreme identifiers on the way.
  task automatic test_priority_order();
    send_item(ACT_ENQ, 16'h0000, 1'b1, 1'b0);
    send_item(ACT_ENQ, 16'hFFFF, 1'b1, 1'b1);
    send_item(ACT_ENQ, 16'h5A5A, 1'b0, 1'b0);
    send_item(ACT_ENQ, 16'hA5A5, 1'b0, 1'b1);
    send_item(ACT_ENQ, 16'h0001, 1'b0, 1'b1);
    repeat (6) send_item(ACT_DEQ, 16'h0000, 1'b0, 1'b0);
  endtask

  // A clear must empty every class, after which the queues work again.
  task automatic test_clear_flushes();
    send_item(ACT_ENQ, 16'h8001, 1'b0, 1'b1);
    send_item(ACT_ENQ, 16'h7FFE, 1'b1, 1'b0);
    send_item(ACT_CLEAR, 16'h0000, 1'b0, 1'b0);
    send_item(ACT_DEQ, 16'h0000, 1'b0, 1'b0);
    send_item(ACT_ENQ, 16'hC3C3, 1'b1, 1'b1);
    send_item(ACT_DEQ, 16'h0000, 1'b0, 1'b0);
  endtask

  // The output side is held off while one class is filled past its depth,
  // so the block backs up into its input; the last enqueues are dropped as
  // full. The sender then waits for every result before draining the class.
  task automatic test_full_class_backpressure();
    send_item(ACT_CLEAR, 16'h0000, 1'b0, 1'b0);
    hold_orders++;
    for (int i = 0; i < CLASS_DEPTH + 2; i++) begin
      send_item(ACT_ENQ, 16'(i * 16'h0F0F + 1), 1'b1, 1'b1);
    end
    wait_all_results();
    repeat (CLASS_DEPTH + 1) send_item(ACT_DEQ, 16'h0000, 1'b0, 1'b0);
  endtask

  // Random traffic in segments that lean toward enqueues or dequeues, so the
  // classes swing between full and empty. One segment runs without idling.
  task automatic test_random_traffic();
    int unsigned enq_pct;
    int unsigned roll;
    logic [1:0] act;
    logic [IdW-1:0] id;
    for (int seg = 0; seg < 7; seg++) begin
      case (seg)
        0: enq_pct = 75;
        1: enq_pct = 20;
        2: enq_pct = 60;
        3: enq_pct = 45;
        4: enq_pct = 85;
        5: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      idle_en = (seg != 3);
      for (int n = 0; n < 150; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          act = ACT_CLEAR;
        end else if (roll < 4) begin
          act = ACT_UNUSED;
        end else if (roll < 4 + enq_pct * 96 / 100) begin
          act = ACT_ENQ;
        end else begin
          act = ACT_DEQ;
        end
        case ($urandom_range(0, 15))
          0: id = '0;
          1: id = '1;
          default: id = IdW'($urandom);
        endcase
        send_item(act, id, 1'($urandom), 1'($urandom));
      end
    end
    idle_en = 1'b1;
  endtask

  // Receiver: random stalls, or a long counted hold when the test asks.
  always @(posedge clk_i) begin
    if (hold_orders != hold_seen) begin
      hold_seen = hold_orders;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Checker: every result item handed over is matched against the oldest
  // expected result.
  always @(posedge clk_i) begin : check_results
    tower_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d id %h cargo %b large %b",
                 $time, status_o, out_id_o, out_cargo_o, out_large_o);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, status_o);
          fail_cnt++;
        end
        if (out_id_o !== want.id) begin
          $display("%0t: out_id mismatch: expected %h actual %h",
                   $time, want.id, out_id_o);
          fail_cnt++;
        end
        if (out_cargo_o !== want.cargo) begin
          $display("%0t: out_cargo mismatch: expected %b actual %b",
                   $time, want.cargo, out_cargo_o);
          fail_cnt++;
        end
        if (out_large_o !== want.large_flag) begin
          $display("%0t: out_large mismatch: expected %b actual %b",
                   $time, want.large_flag, out_large_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < NumClasses; c++) begin
      head_idx[c] = 0;
      tail_idx[c] = 0;
      fill_cnt[c] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused();
    test_priority_order();
    test_clear_flushes();
    test_full_class_backpressure();
    test_random_traffic();

    // Let the last results drain, then give any stray result time to show up.
    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
